### hw/rtl/cpsm_pkg.sv
// shared constants, types and codes of the capture period speed meter
`timescale 1ns / 1ps
package cpsm_pkg;

	localparam int RING_DEPTH  = 18;
	localparam int GROUP_SIZE  = 6;
	localparam int GROUP_COUNT = RING_DEPTH / GROUP_SIZE;
	localparam int TRIM_COUNT  = GROUP_SIZE - 2;
	localparam int TRIM_SHIFT  = $clog2(TRIM_COUNT);
	localparam int ADDR_W      = $clog2(RING_DEPTH);
	localparam int GPOS_W      = $clog2(GROUP_SIZE);
	localparam int PERIOD_W    = 18;
	localparam int COUNT_W     = 16;
	localparam int OVF_W       = 8;
	localparam int NUM_W       = 24;
	localparam int SPEED_W     = 16;
	localparam int SUM_W       = PERIOD_W + $clog2(GROUP_SIZE);
	localparam int TOTAL_W     = PERIOD_W + $clog2(GROUP_COUNT + 1);
	localparam int DIVIDEND_W  = NUM_W;
	localparam int DIVISOR_W   = PERIOD_W + 3;
	localparam int STEP_W      = $clog2(DIVIDEND_W + 1);

	// mean over the groups by reciprocal multiply, exact for every total below 2**TOTAL_W
	localparam int AVG_SHIFT   = TOTAL_W + $clog2(GROUP_COUNT);
	localparam int AVG_MUL_W   = TOTAL_W + 1;
	localparam logic [AVG_MUL_W-1:0] AVG_MUL =
		AVG_MUL_W'(((longint'(1) << AVG_SHIFT) + GROUP_COUNT - 1) / GROUP_COUNT);

	localparam logic [PERIOD_W-1:0] MAX_PERIOD_RST = PERIOD_W'(250000);
	localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST = PERIOD_W'(250);
	localparam logic [OVF_W-1:0]    OVF_LIMIT_RST  = OVF_W'(6);
	localparam logic [NUM_W-1:0]    NUMERATOR_RST  = NUM_W'(15000000);
	localparam logic [OVF_W-1:0]    OVF_SAT        = '1;
	localparam logic [SPEED_W-1:0]  SPEED_SAT      = '1;

	typedef enum logic [1:0] {
		OP_CAPTURE  = 2'd0,
		OP_OVERFLOW = 2'd1,
		OP_READ     = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_MAX_PERIOD = 2'd0,
		REG_MIN_PERIOD = 2'd1,
		REG_OVF_LIMIT  = 2'd2,
		REG_NUMERATOR  = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_SUM,
		ST_AVG,
		ST_DIVS_GO,
		ST_DIVS_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [DIVIDEND_W-1:0] quotient;
	} div_rsp_t;

endpackage

### hw/rtl/cpsm_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module cpsm_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 18
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/cpsm_div.sv
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module cpsm_div
	import cpsm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     cnt_q;
	logic [DIVISOR_W:0]    rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [DIVISOR_W:0]    rem_sh;
	logic                  ge;

	assign rem_sh = {rem_q[DIVISOR_W-1:0], quo_q[DIVIDEND_W-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (cnt_q == STEP_W'(DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("divider done without a run");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider still busy at done");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < {1'b0, dvs_q}) else $error("remainder not below divisor");

endmodule

### hw/rtl/capture_period_speed_meter.sv
// top level: capture period ring, stall fill, trimmed-mean speed read
`timescale 1ns / 1ps
// One input word at a time. A capture edge, an overflow tick that does not stop the meter, an
// unknown operation or a read before the ring holds data goes through the finish state to the
// output register. An overflow tick that reaches the limit rewrites all 18 ring entries, one
// per cycle. A speed read sweeps the 18 ring entries through the ring memory's single read
// port, forms the mean over the three groups with a constant reciprocal multiply, then runs the
// 24-step divider once for the speed; a zero mean saturates the speed instead. The next word
// is accepted once the current one is finished; a finished result waits in the output register.
module capture_period_speed_meter
	import cpsm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [COUNT_W-1:0]    s_tdata,   // capture_count
	input  logic [1:0]            s_tuser,   // operation
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [SPEED_W-1:0]    m_tdata,   // speed
	output logic                  m_tuser,   // stopped
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [NUM_W-1:0]      cfg_data
);

	state_t state_q, state_d;

	logic [PERIOD_W-1:0] max_q, min_q;
	logic [OVF_W-1:0]    limit_q;
	logic [NUM_W-1:0]    num_q;

	logic [COUNT_W-1:0]  last_q;
	logic [OVF_W-1:0]    ovf_q;
	logic [ADDR_W-1:0]   widx_q;
	logic                valid_q;
	logic                stall_q;

	logic [ADDR_W-1:0]   fcnt_q;
	logic [ADDR_W:0]     rcnt_q;
	logic                rdv_s1;
	logic [ADDR_W-1:0]   ridx_s1;
	logic [GPOS_W-1:0]   gpos_q;
	logic [SUM_W-1:0]    gsum_q;
	logic [PERIOD_W-1:0] ghi_q, glo_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [PERIOD_W-1:0] avg_q;
	logic [SPEED_W-1:0]  speed_q;

	logic                m_tvalid_q;
	logic [SPEED_W-1:0]  m_speed_q;
	logic                m_stop_q;

	logic                accept;
	op_t                 op;
	logic                fill_start;
	logic                out_free;

	logic [NUM_W-1:0]    raw;
	logic [NUM_W-1:0]    diff;
	logic [PERIOD_W-1:0] p_max;
	logic [PERIOD_W-1:0] period;
	logic [ADDR_W-1:0]   widx_n;
	logic [OVF_W-1:0]    ovf_n;

	logic                ram_we, ram_re;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [PERIOD_W-1:0] ram_wdata;
	logic [PERIOD_W-1:0] ram_rdata;

	logic [SUM_W-1:0]    sum_n, trim;
	logic [PERIOD_W-1:0] hi_n, lo_n;
	logic                gfirst, glast, sweep_end;

	logic [TOTAL_W+AVG_MUL_W-1:0] avg_prod;
	logic [PERIOD_W-1:0] avg_n;

	div_req_t            dreq;
	div_rsp_t            drsp;

	assign s_tready  = state_q == ST_IDLE;
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign op        = op_t'(s_tuser);
	assign out_free  = !m_tvalid_q || m_tready;

	// capture period
	assign raw    = {ovf_q, s_tdata};
	assign diff   = raw - NUM_W'(last_q);
	assign p_max  = (diff >= NUM_W'(max_q)) ? max_q : diff[PERIOD_W-1:0];
	assign period = (raw < NUM_W'(last_q)) ? max_q : ((p_max <= min_q) ? min_q : p_max);
	assign widx_n = (widx_q == ADDR_W'(RING_DEPTH - 1)) ? '0 : widx_q + ADDR_W'(1);
	assign ovf_n  = (ovf_q == OVF_SAT) ? OVF_SAT : ovf_q + OVF_W'(1);
	assign fill_start = accept && op == OP_OVERFLOW && ovf_n >= limit_q;

	// group trim
	assign gfirst    = gpos_q == '0;
	assign glast     = gpos_q == GPOS_W'(GROUP_SIZE - 1);
	assign sum_n     = gfirst ? SUM_W'(ram_rdata) : gsum_q + SUM_W'(ram_rdata);
	assign hi_n      = (gfirst || ram_rdata > ghi_q) ? ram_rdata : ghi_q;
	assign lo_n      = (gfirst || ram_rdata < glo_q) ? ram_rdata : glo_q;
	assign trim      = (sum_n - SUM_W'(hi_n) - SUM_W'(lo_n)) >> TRIM_SHIFT;
	assign sweep_end = rdv_s1 && ridx_s1 == ADDR_W'(RING_DEPTH - 1);

	// mean over the groups
	assign avg_prod = (TOTAL_W + AVG_MUL_W)'(total_q) * (TOTAL_W + AVG_MUL_W)'(AVG_MUL);
	assign avg_n    = avg_prod[AVG_SHIFT +: PERIOD_W];

	cpsm_ram #(.WIDTH(PERIOD_W), .DEPTH(RING_DEPTH)) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rcnt_q[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	cpsm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (fill_start) begin
						state_d = ST_FILL;
					end else if (op == OP_READ && valid_q) begin
						state_d = ST_SUM;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_FILL: begin
				if (fcnt_q == ADDR_W'(RING_DEPTH - 1)) begin
					state_d = ST_FINISH;
				end
			end
			ST_SUM: begin
				if (sweep_end) begin
					state_d = ST_AVG;
				end
			end
			ST_AVG: state_d = (avg_n == '0) ? ST_FINISH : ST_DIVS_GO;
			ST_DIVS_GO: state_d = ST_DIVS_WAIT;
			ST_DIVS_WAIT: begin
				if (drsp.done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ram_we        = 1'b0;
		ram_waddr     = widx_n;
		ram_wdata     = period;
		ram_re        = 1'b0;
		dreq.start    = 1'b0;
		dreq.dividend = num_q;
		dreq.divisor  = {avg_q, 3'b000};
		case (state_q)
			ST_IDLE: begin
				ram_we = accept && op == OP_CAPTURE;
			end
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = fcnt_q;
				ram_wdata = max_q;
			end
			ST_SUM: begin
				ram_re = rcnt_q != (ADDR_W + 1)'(RING_DEPTH);
			end
			ST_DIVS_GO: begin
				dreq.start = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			max_q      <= MAX_PERIOD_RST;
			min_q      <= MIN_PERIOD_RST;
			limit_q    <= OVF_LIMIT_RST;
			num_q      <= NUMERATOR_RST;
			last_q     <= '0;
			ovf_q      <= '0;
			widx_q     <= '0;
			valid_q    <= 1'b0;
			stall_q    <= 1'b0;
			fcnt_q     <= '0;
			rcnt_q     <= '0;
			rdv_s1     <= 1'b0;
			gpos_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_MAX_PERIOD: max_q   <= cfg_data[PERIOD_W-1:0];
					REG_MIN_PERIOD: min_q   <= cfg_data[PERIOD_W-1:0];
					REG_OVF_LIMIT:  limit_q <= cfg_data[OVF_W-1:0];
					REG_NUMERATOR:  num_q   <= cfg_data;
					default: begin
					end
				endcase
			end
			if (accept) begin
				case (op)
					OP_CAPTURE: begin
						ovf_q   <= '0;
						stall_q <= 1'b0;
						last_q  <= s_tdata;
						widx_q  <= widx_n;
						if (widx_n == '0) begin
							valid_q <= 1'b1;
						end
					end
					OP_OVERFLOW: begin
						ovf_q <= ovf_n;
						if (fill_start) begin
							stall_q <= 1'b1;
							valid_q <= 1'b1;
						end
					end
					default: begin
					end
				endcase
				fcnt_q <= '0;
				rcnt_q <= '0;
				gpos_q <= '0;
			end
			if (state_q == ST_FILL) begin
				fcnt_q <= fcnt_q + ADDR_W'(1);
			end
			rdv_s1 <= ram_re;
			if (ram_re) begin
				rcnt_q <= rcnt_q + (ADDR_W + 1)'(1);
			end
			if (rdv_s1) begin
				gpos_q <= glast ? '0 : gpos_q + GPOS_W'(1);
			end
			if (state_q == ST_FINISH && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			speed_q <= '0;
			total_q <= '0;
		end
		if (ram_re) begin
			ridx_s1 <= rcnt_q[ADDR_W-1:0];
		end
		if (rdv_s1) begin
			gsum_q <= sum_n;
			ghi_q  <= hi_n;
			glo_q  <= lo_n;
			if (glast) begin
				total_q <= total_q + TOTAL_W'(trim);
			end
		end
		if (state_q == ST_AVG) begin
			avg_q <= avg_n;
			if (avg_n == '0) begin
				speed_q <= SPEED_SAT;
			end
		end
		if (state_q == ST_DIVS_WAIT && drsp.done) begin
			speed_q <= (drsp.quotient[DIVIDEND_W-1:SPEED_W] != '0) ? SPEED_SAT :
				drsp.quotient[SPEED_W-1:0];
		end
		if (state_q == ST_FINISH && out_free) begin
			m_speed_q <= speed_q;
			m_stop_q  <= stall_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_speed_q;
	assign m_tuser  = m_stop_q;

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_IDLE || state_q == ST_FILL))
		else $error("ring written outside edge or fill");
	a_word_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q) == ST_FINISH)
		else $error("result word without finished item");
	a_fill_sets_stop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FILL |-> stall_q && valid_q)
		else $error("fill without stop");
	a_read_needs_ring: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> valid_q && !ram_we)
		else $error("ring read before it holds data");

endmodule
